// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes shared by the indexed list store modules.
// ----------------------------------------------------------------------------
package ils_pkg;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DROP   = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // Status codes carried in the status field.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  position;
        logic [31:0] payload;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_word;
        logic [6:0]  item_count;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_LAST,
        S_SHIFT_DN,
        S_RD_WAIT,
        S_DONE
    } state_t;

endpackage

// ===== rtl/ils_ram.sv =====
// ----------------------------------------------------------------------------
// ils_ram
// Simple dual-port entry memory: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/ils_ctrl.sv =====
// ----------------------------------------------------------------------------
// ils_ctrl
// Command sequencer: decodes a command, runs the entry shift through the
// memory one entry a cycle, and presents the result.
// ----------------------------------------------------------------------------
module ils_ctrl #(
    parameter int CAPACITY = 64,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  ils_pkg::cmd_item_t    cmd_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ils_pkg::rsp_item_t    res,
    output logic                  mem_we,
    output logic [IDX_W-1:0]      mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [IDX_W-1:0]      mem_raddr,
    input  logic [DATA_WIDTH-1:0] mem_rdata
);

    localparam int WIDE = CNT_W + 7;

    ils_pkg::state_t       state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [IDX_W-1:0]      lim_reg, lim_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           rword_reg, rword_next;

    logic [WIDE-1:0]       pos_w, cnt_w, cnt_out_w;
    logic [IDX_W-1:0]      pos_i, cnt_i;
    logic [63:0]           pay_wide, rd_wide;
    logic [DATA_WIDTH-1:0] in_word;
    logic                  accept, full, ins_bad, rr_bad, ins_tail, rm_tail;
    logic                  up_last, dn_last;

    // Shared decode of the incoming command against the current count.
    always_comb
    begin
        accept   = cmd_valid && (state_reg == ils_pkg::S_IDLE);
        pos_w    = WIDE'(cmd_data.position);
        cnt_w    = WIDE'(cnt_reg);
        pos_i    = pos_w[IDX_W-1:0];
        cnt_i    = cnt_reg[IDX_W-1:0];
        full     = cnt_reg >= CNT_W'(CAPACITY);
        ins_bad  = pos_w > cnt_w;
        rr_bad   = pos_w >= cnt_w;
        ins_tail = pos_w == cnt_w;
        rm_tail  = (pos_w + WIDE'(1)) == cnt_w;
        pay_wide = 64'(cmd_data.payload);
        in_word  = pay_wide[DATA_WIDTH-1:0];
        rd_wide  = 64'(mem_rdata);
        up_last  = ptr_reg == (lim_reg + IDX_W'(1));
        dn_last  = (CNT_W'(ptr_reg) + CNT_W'(1)) == cnt_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ils_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ils_pkg::S_DONE;
                    case (cmd_data.cmd)
                        ils_pkg::CMD_INSERT:
                        begin
                            if (!ins_bad && !full && !ins_tail)
                            begin
                                state_next = ils_pkg::S_SHIFT_UP;
                            end
                        end
                        ils_pkg::CMD_REMOVE:
                        begin
                            if (!rr_bad && !rm_tail)
                            begin
                                state_next = ils_pkg::S_SHIFT_DN;
                            end
                        end
                        ils_pkg::CMD_READ:
                        begin
                            if (!rr_bad)
                            begin
                                state_next = ils_pkg::S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = ils_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ils_pkg::S_SHIFT_UP:
            begin
                if (up_last)
                begin
                    state_next = ils_pkg::S_INS_LAST;
                end
            end
            ils_pkg::S_INS_LAST:
            begin
                state_next = ils_pkg::S_DONE;
            end
            ils_pkg::S_SHIFT_DN:
            begin
                if (dn_last)
                begin
                    state_next = ils_pkg::S_DONE;
                end
            end
            ils_pkg::S_RD_WAIT:
            begin
                state_next = ils_pkg::S_DONE;
            end
            ils_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ils_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ils_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: handshakes and memory port controls.
    always_comb
    begin
        cmd_ready = state_reg == ils_pkg::S_IDLE;
        res_valid = state_reg == ils_pkg::S_DONE;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = ptr_reg - IDX_W'(2);
        unique case (state_reg)
            ils_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_data.cmd)
                        ils_pkg::CMD_APPEND:
                        begin
                            mem_we    = !full;
                            mem_waddr = cnt_i;
                            mem_wdata = in_word;
                        end
                        ils_pkg::CMD_INSERT:
                        begin
                            mem_we    = !ins_bad && !full && ins_tail;
                            mem_waddr = pos_i;
                            mem_wdata = in_word;
                            mem_re    = !ins_bad && !full && !ins_tail;
                            mem_raddr = cnt_i - IDX_W'(1);
                        end
                        ils_pkg::CMD_REMOVE:
                        begin
                            mem_re    = !rr_bad && !rm_tail;
                            mem_raddr = pos_i + IDX_W'(1);
                        end
                        ils_pkg::CMD_READ:
                        begin
                            mem_re    = !rr_bad;
                            mem_raddr = pos_i;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            ils_pkg::S_SHIFT_UP:
            begin
                mem_we    = 1'b1;
                mem_re    = !up_last;
                mem_raddr = ptr_reg - IDX_W'(2);
            end
            ils_pkg::S_INS_LAST:
            begin
                mem_we    = 1'b1;
                mem_waddr = lim_reg;
                mem_wdata = word_reg;
            end
            ils_pkg::S_SHIFT_DN:
            begin
                mem_we    = 1'b1;
                mem_re    = !dn_last;
                mem_raddr = ptr_reg + IDX_W'(2);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Datapath registers' next values.
    always_comb
    begin
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        lim_next    = lim_reg;
        word_next   = word_reg;
        status_next = status_reg;
        rword_next  = rword_reg;
        if (accept)
        begin
            status_next = ils_pkg::ST_OK;
            rword_next  = '0;
            word_next   = in_word;
            lim_next    = pos_i;
            case (cmd_data.cmd)
                ils_pkg::CMD_APPEND:
                begin
                    if (full)
                    begin
                        status_next = ils_pkg::ST_FULL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ils_pkg::CMD_INSERT:
                begin
                    ptr_next = cnt_i;
                    if (ins_bad)
                    begin
                        status_next = ils_pkg::ST_BADPOS;
                    end
                    else if (full)
                    begin
                        status_next = ils_pkg::ST_FULL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ils_pkg::CMD_DROP:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                ils_pkg::CMD_REMOVE:
                begin
                    ptr_next = pos_i;
                    if (rr_bad)
                    begin
                        status_next = ils_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                ils_pkg::CMD_READ:
                begin
                    if (rr_bad)
                    begin
                        status_next = ils_pkg::ST_BADPOS;
                    end
                end
                ils_pkg::CMD_CLEAR:
                begin
                    cnt_next = '0;
                end
                default:
                begin
                    status_next = ils_pkg::ST_OK;
                end
            endcase
        end
        else if (state_reg == ils_pkg::S_SHIFT_UP)
        begin
            ptr_next = ptr_reg - IDX_W'(1);
        end
        else if (state_reg == ils_pkg::S_SHIFT_DN)
        begin
            ptr_next = ptr_reg + IDX_W'(1);
        end
        else if (state_reg == ils_pkg::S_RD_WAIT)
        begin
            rword_next = rd_wide[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ils_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        lim_reg    <= lim_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        rword_reg  <= rword_next;
    end

    always_comb
    begin
        cnt_out_w      = WIDE'(cnt_reg);
        res.status     = status_reg;
        res.read_word  = rword_reg;
        res.item_count = cnt_out_w[6:0];
    end

    // The entry count never goes beyond the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A result that is not taken stays on offer unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result dropped or changed while stalled");

    // The shift never reads the entry that it writes in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry in one cycle");

    // An upward shift always writes above the insert position.
    a_up_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ils_pkg::S_SHIFT_UP) |-> (ptr_reg > lim_reg))
        else $error("upward shift ran below the insert position");

endmodule

// ===== rtl/indexed_list_store_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of up to CAPACITY words with append, insert, drop, remove,
// read and clear commands, each answered by one result beat.
// ----------------------------------------------------------------------------
// Usage
// A command beat enters on cmd_valid/cmd_ready with fields cmd, position and
// payload; each command yields exactly one result beat on rsp_valid/rsp_ready
// carrying status, read_word and item_count (the count after the command).
// The block takes one command at a time. Append, drop, clear, unused codes
// and any rejected command go straight to their result; read first waits on
// the registered read port of the entry memory. Insert and remove at position
// p move every entry behind p by one place, since the single write port of
// the entry memory moves one entry a cycle; insert then writes the new word
// at p. The result then passes through the output register. A new command is
// accepted while an earlier result still waits in the output register; a
// stalled receiver only holds up the block once the next result is ready and
// has nowhere to go. Reset clears the entry count and the handshake state at
// once; the entry memory needs no clearing pass, as only positions below the
// count can ever be read.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
    parameter int CAPACITY = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ils_pkg::cmd_item_t cmd_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ils_pkg::rsp_item_t rsp_data
);

    localparam int IDX_W = $clog2(CAPACITY);

    // Result from the sequencer, handed to the output register.
    logic               res_valid;
    logic               res_ready;
    ils_pkg::rsp_item_t res;

    // Entry memory ports.
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // Output register state.
    logic               rsp_valid_reg, rsp_valid_next;
    ils_pkg::rsp_item_t rsp_data_reg, rsp_data_next;

    ils_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ils_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a new result whenever it is empty or its
    // current beat is being taken in the same cycle.
    always_comb
    begin
        res_ready      = !rsp_valid_reg || rsp_ready;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
